// ===== rtl/crc_pkg.sv =====
package crc_pkg;

  // Defaults and fixed widths
  localparam int CHANNELS_DEF = 4;
  localparam int FRAC_BITS    = 20;
  localparam int RATE_W       = 32;
  localparam int ACH_W        = 44;
  localparam int DIV_BITS     = RATE_W + FRAC_BITS;
  localparam int CNT_W        = $clog2(DIV_BITS);

  // Command codes
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_ROUND  = 2'd1;
  localparam logic [1:0] CMD_RECALC = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  // Band codes; BAND_NONE marks a rate in no band
  localparam logic [1:0] BAND_HIGH = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_LOW  = 2'd2;
  localparam logic [1:0] BAND_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [RATE_W-1:0] ref_rate;
    logic [RATE_W-1:0] target_rate;
    logic [1:0]        channel;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [RATE_W-1:0] ratio;
    logic [ACH_W-1:0]  achieved_rate;
    logic [1:0]        range_code;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       div_step;
    logic       load_table;
    logic       mul_load;
    logic       out_load;
    logic       commit;
    logic       zero_result;
    logic [1:0] status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       band_ok;
    logic       ref_zero;
    logic       div_last;
  } dp_stat_t;

  // Lower bound inclusive, upper bound exclusive
  function automatic logic [1:0] band_of(input logic [RATE_W-1:0] r);
    logic [1:0] code;
    code = BAND_NONE;
    if (r >= 32'd32000000 && r < 32'd56000000) begin
      code = BAND_HIGH;
    end else if (r >= 32'd16000000 && r < 32'd28000000) begin
      code = BAND_MID;
    end else if (r >= 32'd8000000 && r < 32'd14000000) begin
      code = BAND_LOW;
    end
    return code;
  endfunction

endpackage

// ===== rtl/crc_ctrl.sv =====
module crc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  crc_pkg::dp_stat_t  stat,
  output crc_pkg::dp_cmd_t   cmd
);

  crc_pkg::state_t state, state_next;
  logic       out_valid_next;
  logic [1:0] status, status_next;
  logic       zero_res, zero_res_next;
  logic       commit, commit_next;

  // State and result bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crc_pkg::S_IDLE;
      out_valid <= 1'b0;
      status    <= crc_pkg::STAT_OK;
      zero_res  <= 1'b0;
      commit    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      status    <= status_next;
      zero_res  <= zero_res_next;
      commit    <= commit_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    status_next   = status;
    zero_res_next = zero_res;
    commit_next   = commit;
    cmd           = '0;
    in_stall      = 1'b1;
    // output register empties on a transfer
    out_valid_next = out_valid && out_stall;

    case (state)
      crc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = crc_pkg::S_DECODE;
        end
      end
      crc_pkg::S_DECODE: begin
        status_next   = crc_pkg::STAT_OK;
        zero_res_next = 1'b0;
        commit_next   = 1'b0;
        case (stat.command)
          crc_pkg::CMD_SET: begin
            if (stat.band_ok) begin
              commit_next   = 1'b1;
              cmd.div_start = 1'b1;
              state_next    = crc_pkg::S_DIV;
            end else begin
              status_next   = crc_pkg::STAT_RANGE;
              zero_res_next = 1'b1;
              state_next    = crc_pkg::S_DONE;
            end
          end
          crc_pkg::CMD_ROUND: begin
            if (stat.ref_zero) begin
              status_next   = crc_pkg::STAT_ZERO;
              zero_res_next = 1'b1;
              state_next    = crc_pkg::S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = crc_pkg::S_DIV;
            end
          end
          crc_pkg::CMD_RECALC: begin
            cmd.load_table = 1'b1;
            state_next     = crc_pkg::S_MUL;
          end
          default: begin
            zero_res_next = 1'b1;
            state_next    = crc_pkg::S_DONE;
          end
        endcase
      end
      crc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = crc_pkg::S_MUL;
        end
      end
      crc_pkg::S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = crc_pkg::S_DONE;
      end
      crc_pkg::S_DONE: begin
        cmd.zero_result = zero_res;
        cmd.status      = status;
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          cmd.commit     = commit;
          out_valid_next = 1'b1;
          state_next     = crc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = crc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/crc_dpath.sv =====
module crc_dpath #(
  parameter int CHANNELS = crc_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  crc_pkg::in_item_t  in_item,
  input  crc_pkg::dp_cmd_t   cmd,
  output crc_pkg::dp_stat_t  stat,
  output crc_pkg::out_item_t out_item
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW    = crc_pkg::RATE_W;
  localparam int DB    = crc_pkg::DIV_BITS;
  localparam int FB    = crc_pkg::FRAC_BITS;
  localparam int CW    = crc_pkg::CNT_W;

  // Captured item
  logic [1:0]    cmd_q;
  logic [RW-1:0] ref_q;
  logic [RW-1:0] tgt_q;
  logic [1:0]    ch_q;

  // Divider and product
  logic [RW:0]          rem;
  logic [DB-1:0]        num;
  logic [RW-1:0]        quo;
  logic [CW-1:0]        cnt;
  logic [crc_pkg::ACH_W-1:0] ach;

  // Stored state
  logic [RW-1:0] tbl [CHANNELS];
  logic [1:0]    range_code;

  logic [1:0]    band;
  logic          chan_ok;
  logic [RW:0]   rem_sh;
  logic [RW:0]   rem_sub;
  logic          q_bit;
  logic [2*RW-1:0] prod;

  assign band    = crc_pkg::band_of(ref_q);
  assign chan_ok = (3'(ch_q) < 3'(CHANNELS));

  // One restoring step: shift in next numerator bit, subtract if it fits
  assign rem_sh  = {rem[RW-1:0], num[DB-1]};
  assign rem_sub = rem_sh - {1'b0, ref_q};
  assign q_bit   = (rem_sh >= {1'b0, ref_q});

  assign prod = (2*RW)'(quo) * (2*RW)'(ref_q);

  assign stat.command  = cmd_q;
  assign stat.band_ok  = (band != crc_pkg::BAND_NONE);
  assign stat.ref_zero = (ref_q == '0);
  assign stat.div_last = (cnt == CW'(DB - 1));

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q <= in_item.command;
      ref_q <= in_item.ref_rate;
      tgt_q <= in_item.target_rate;
      ch_q  <= in_item.channel;
    end
  end

  // Serial divider, one quotient bit per cycle; quo also holds the
  // ratio read back for a recalculation
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      num <= {tgt_q, FB'(0)};
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= q_bit ? rem_sub : rem_sh;
      num <= {num[DB-2:0], 1'b0};
      quo <= {quo[RW-2:0], q_bit};
      cnt <= cnt + 1'b1;
    end else if (cmd.load_table) begin
      quo <= chan_ok ? tbl[ch_q[IDX_W-1:0]] : '0;
    end
  end

  // Achieved rate, product registered
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ach <= prod[2*RW-1:FB];
    end
  end

  // Ratio table and band code
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        tbl[i] <= '0;
      end
      range_code <= crc_pkg::BAND_HIGH;
    end else if (cmd.commit) begin
      range_code <= band;
      if (chan_ok) begin
        tbl[ch_q[IDX_W-1:0]] <= quo;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.status        <= cmd.status;
      out_item.ratio         <= cmd.zero_result ? '0 : quo;
      out_item.achieved_rate <= cmd.zero_result ? '0 : ach;
      out_item.range_code    <= cmd.commit ? band : range_code;
    end
  end

endmodule

// ===== rtl/clock_ratio_calculator.sv =====
// Fractional-N ratio unit. Each transfer in gives one transfer out. Set rate
// and round rate run a serial restoring divider that produces one quotient
// bit per cycle over 52 bits (capture, decode, 52 divide steps, multiply,
// output); a rejected request skips it. Recalculate skips the divider. One
// item is worked on at a time; the input is stalled from acceptance until the
// result is loaded into the output register, which may still hold the
// previous result while the next item is taken in. The ratio table is
// cleared by reset.
module clock_ratio_calculator #(
  parameter int CHANNELS = crc_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  crc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output crc_pkg::out_item_t out_item
);

  crc_pkg::dp_cmd_t  cmd;
  crc_pkg::dp_stat_t stat;

  crc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  crc_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ===== sim/clock_ratio_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the ratio unit, predicts every result from the
// accepted requests and compares each result transfer with the oldest
// prediction.
module clock_ratio_checker #(
  parameter int CHANNELS = crc_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  crc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  crc_pkg::out_item_t out_item,
  output int                 err_count,
  output int                 pending
);

  localparam int RW = crc_pkg::RATE_W;
  localparam int DB = crc_pkg::DIV_BITS;
  localparam int FB = crc_pkg::FRAC_BITS;
  localparam int AW = crc_pkg::ACH_W;

  // Band limits: lower bound inclusive, upper bound exclusive
  localparam logic [RW-1:0] HIGH_MIN = 32'd32_000_000;
  localparam logic [RW-1:0] HIGH_MAX = 32'd56_000_000;
  localparam logic [RW-1:0] MID_MIN  = 32'd16_000_000;
  localparam logic [RW-1:0] MID_MAX  = 32'd28_000_000;
  localparam logic [RW-1:0] LOW_MIN  = 32'd8_000_000;
  localparam logic [RW-1:0] LOW_MAX  = 32'd14_000_000;

  // Predicted copy of the unit's state
  logic [RW-1:0] ratio_store [crc_pkg::CHANNELS_DEF];
  logic [1:0]    active_channel;
  logic [1:0]    band_code;

  crc_pkg::out_item_t expected_results [$];

  initial err_count = 0;
  initial pending = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  // (target << 20) / ref, truncated to 32 bits; ref must not be zero
  function automatic logic [RW-1:0] ratio_for(input logic [RW-1:0] ref_hz,
                                              input logic [RW-1:0] tgt_hz);
    logic [DB-1:0] num;
    logic [DB-1:0] quo;
    num = DB'(tgt_hz) << FB;
    quo = num / DB'(ref_hz);
    return quo[RW-1:0];
  endfunction

  // (ratio * ref) >> 20, 44 bits
  function automatic logic [AW-1:0] rate_for(input logic [RW-1:0] ratio,
                                             input logic [RW-1:0] ref_hz);
    logic [63:0] prod;
    prod = 64'(ratio) * 64'(ref_hz);
    return prod[FB +: AW];
  endfunction

  // Works out the result of one request and updates the predicted state
  function automatic crc_pkg::out_item_t predict_ratio_result(input crc_pkg::in_item_t req);
    crc_pkg::out_item_t res;
    logic [1:0]         band;
    res = '0;
    res.status = crc_pkg::STAT_OK;
    case (req.command)
      crc_pkg::CMD_SET: begin
        if (req.ref_rate >= HIGH_MIN && req.ref_rate < HIGH_MAX) begin
          band = crc_pkg::BAND_HIGH;
        end else if (req.ref_rate >= MID_MIN && req.ref_rate < MID_MAX) begin
          band = crc_pkg::BAND_MID;
        end else if (req.ref_rate >= LOW_MIN && req.ref_rate < LOW_MAX) begin
          band = crc_pkg::BAND_LOW;
        end else begin
          band = crc_pkg::BAND_NONE;
        end
        if (band == crc_pkg::BAND_NONE) begin
          res.status = crc_pkg::STAT_RANGE;
        end else begin
          res.ratio         = ratio_for(req.ref_rate, req.target_rate);
          res.achieved_rate = rate_for(res.ratio, req.ref_rate);
          band_code         = band;
          if (int'(req.channel) < CHANNELS) begin
            ratio_store[req.channel] = res.ratio;
            active_channel           = req.channel;
          end
        end
      end
      crc_pkg::CMD_ROUND: begin
        if (req.ref_rate == '0) begin
          res.status = crc_pkg::STAT_ZERO;
        end else begin
          res.ratio         = ratio_for(req.ref_rate, req.target_rate);
          res.achieved_rate = rate_for(res.ratio, req.ref_rate);
        end
      end
      crc_pkg::CMD_RECALC: begin
        if (int'(req.channel) < CHANNELS) begin
          res.ratio = ratio_store[req.channel];
        end
        res.achieved_rate = rate_for(res.ratio, req.ref_rate);
      end
      default: begin
        // unused command: no change, zero ratio and rate
      end
    endcase
    res.range_code = band_code;
    return res;
  endfunction

  // Result transfers are checked before the request of the same edge is added
  always @(posedge clk) begin : watch
    crc_pkg::out_item_t want;
    if (rst) begin
      for (int i = 0; i < crc_pkg::CHANNELS_DEF; i++) begin
        ratio_store[i] = '0;
      end
      active_channel = '0;
      band_code      = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status) begin
            report_mismatch($sformatf("status: got %0d, want %0d",
                                      out_item.status, want.status));
          end
          if (out_item.ratio !== want.ratio) begin
            report_mismatch($sformatf("ratio: got %h, want %h",
                                      out_item.ratio, want.ratio));
          end
          if (out_item.achieved_rate !== want.achieved_rate) begin
            report_mismatch($sformatf("achieved_rate: got %0d, want %0d",
                                      out_item.achieved_rate, want.achieved_rate));
          end
          if (out_item.range_code !== want.range_code) begin
            report_mismatch($sformatf("range_code: got %0d, want %0d",
                                      out_item.range_code, want.range_code));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_ratio_result(in_item));
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== sim/clock_ratio_calculator_tb.sv =====
`timescale 1ns / 100ps

module clock_ratio_calculator_tb;

  // Command code with no meaning; the unit must ignore it
  localparam logic [1:0] CMD_NONE     = 2'd3;
  localparam int         RANDOM_ITEMS = 400;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  crc_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  crc_pkg::out_item_t out_item;
  int                 err_count;
  int                 pending;
  int                 stall_left = 0;
  int                 cyc        = 0;

  clock_ratio_calculator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  clock_ratio_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall limit, far above the slowest legal run
  initial begin
    #6_000_000;
    $display("clock_ratio_calculator_tb: errors");
    $finish;
  end

  // Result side back-pressure: quiet stretches, short bursts, rare long holds
  always @(posedge clk) begin : stall_gen
    int r;
    cyc <= cyc + 1;
    r = $urandom_range(0, 99);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ((cyc / 300) % 4 == 0) begin
      out_stall <= 1'b0;
    end else if (r < 20) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else if (r < 22) begin
      stall_left <= $urandom_range(20, 80);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Idle cycles between request transfers, mostly none or short
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Reference rate inside one of the three bands, edges now and then
  function automatic logic [crc_pkg::RATE_W-1:0] band_ref();
    int lo;
    int hi;
    case ($urandom_range(0, 2))
      0: begin
        lo = 32_000_000;
        hi = 56_000_000;
      end
      1: begin
        lo = 16_000_000;
        hi = 28_000_000;
      end
      default: begin
        lo = 8_000_000;
        hi = 14_000_000;
      end
    endcase
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi - 1;
      default: return $urandom_range(lo, hi - 1);
    endcase
  endfunction

  // One request transfer, then an optional idle gap
  task automatic issue(input logic [1:0] cmd,
                       input logic [crc_pkg::RATE_W-1:0] ref_hz,
                       input logic [crc_pkg::RATE_W-1:0] tgt_hz,
                       input logic [1:0] ch,
                       input bit calm);
    crc_pkg::in_item_t req;
    int                gap;
    req.command     = cmd;
    req.ref_rate    = ref_hz;
    req.target_rate = tgt_hz;
    req.channel     = ch;
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap(calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly in-band set rate followed by reads, plus noise
  task automatic issue_random(input bit calm);
    logic [1:0]                 cmd;
    logic [crc_pkg::RATE_W-1:0] ref_hz;
    logic [crc_pkg::RATE_W-1:0] tgt_hz;
    int                         pick;
    pick   = $urandom_range(0, 99);
    tgt_hz = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(1_000_000, 250_000_000);
    ref_hz = band_ref();
    if (pick < 45) begin
      cmd = crc_pkg::CMD_SET;
    end else if (pick < 55) begin
      cmd    = crc_pkg::CMD_SET;
      ref_hz = $urandom();
    end else if (pick < 95) begin
      cmd = (pick < 75) ? crc_pkg::CMD_ROUND : crc_pkg::CMD_RECALC;
      if ($urandom_range(0, 9) == 0) begin
        ref_hz = '0;
      end else if ($urandom_range(0, 2) == 0) begin
        ref_hz = $urandom();
      end
    end else begin
      cmd    = CMD_NONE;
      ref_hz = $urandom();
    end
    issue(cmd, ref_hz, tgt_hz, 2'($urandom_range(0, 3)), calm);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: untouched entry, band edges, zero reference, truncation
    issue(crc_pkg::CMD_RECALC, 32'hFFFF_FFFF,  32'd0,           2'd3, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd32_000_000, 32'd0,           2'd0, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd55_999_999, 32'hFFFF_FFFF,   2'd1, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd56_000_000, 32'd100_000_000, 2'd2, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd31_999_999, 32'd100_000_000, 2'd2, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd16_000_000, 32'd24_576_000,  2'd2, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd27_999_999, 32'd49_152_000,  2'd3, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd28_000_000, 32'd49_152_000,  2'd0, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd15_999_999, 32'd49_152_000,  2'd0, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd8_000_000,  32'hFFFF_FFFF,   2'd3, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd13_999_999, 32'd12_288_000,  2'd0, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd14_000_000, 32'd12_288_000,  2'd1, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd7_999_999,  32'd12_288_000,  2'd1, 1'b0);
    issue(crc_pkg::CMD_SET,    32'd0,          32'd12_288_000,  2'd1, 1'b0);
    issue(crc_pkg::CMD_SET,    32'hFFFF_FFFF,  32'hFFFF_FFFF,   2'd1, 1'b0);
    issue(crc_pkg::CMD_ROUND,  32'd0,          32'd22_579_200,  2'd0, 1'b0);
    issue(crc_pkg::CMD_ROUND,  32'd1,          32'hFFFF_FFFF,   2'd0, 1'b0);
    issue(crc_pkg::CMD_ROUND,  32'hFFFF_FFFF,  32'hFFFF_FFFF,   2'd2, 1'b0);
    issue(crc_pkg::CMD_RECALC, 32'd0,          32'd0,           2'd1, 1'b0);
    issue(crc_pkg::CMD_RECALC, 32'hFFFF_FFFF,  32'd0,           2'd3, 1'b0);
    issue(CMD_NONE,            32'd24_000_000, 32'd22_579_200,  2'd2, 1'b0);
    issue(crc_pkg::CMD_RECALC, 32'd24_000_000, 32'd0,           2'd2, 1'b0);
    issue(crc_pkg::CMD_ROUND,  32'd24_000_000, 32'd22_579_200,  2'd0, 1'b0);

    // Random traffic, with stretches of back-to-back transfers
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue_random((i / 50) % 3 == 1);
    end
    in_valid <= 1'b0;

    // Drain, then allow for one full divide before the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_count == 0) begin
      $display("clock_ratio_calculator_tb: clean");
    end else begin
      $display("clock_ratio_calculator_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crc_pkg.sv
rtl/crc_ctrl.sv
rtl/crc_dpath.sv
rtl/clock_ratio_calculator.sv
sim/clock_ratio_checker.sv
sim/clock_ratio_calculator_tb.sv
